### sv/utsc_pkg.sv
// ----------------------------------------------------------------------------
// utsc_pkg
// Shared constants and types for the triple singleton counter.
// ----------------------------------------------------------------------------
package utsc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int VALUE_BITS    = 16;
    localparam int KEY_W         = 3 * VALUE_BITS;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_W         = 11;

    localparam logic [1:0] CNT_ONCE  = 2'd1;
    localparam logic [1:0] CNT_TWICE = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             start;
    } utsc_item_t;

endpackage

### sv/utsc_front.sv
// ----------------------------------------------------------------------------
// utsc_front
// Accepts input beats, sorts each triple into a canonical key and queues it.
// ----------------------------------------------------------------------------
module utsc_front
    import utsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      in_a,
    input  logic [15:0]      in_b,
    input  logic [15:0]      in_c,
    input  logic             in_start,
    output logic             q_valid,
    input  logic             q_ready,
    output utsc_item_t       q_item
);

    logic [VALUE_BITS-1:0] a0, b0, c0, a1, b1, c1, a2, b2;
    utsc_item_t            new_item;

    utsc_item_t slot_reg [2];
    logic [1:0] fill_reg, fill_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push, pop;

    // three compare-exchange steps: descending order
    always_comb
    begin
        a0 = in_a[VALUE_BITS-1:0];
        b0 = in_b[VALUE_BITS-1:0];
        c0 = in_c[VALUE_BITS-1:0];
        a1 = (a0 < b0) ? b0 : a0;
        b1 = (a0 < b0) ? a0 : b0;
        b2 = (b1 < c0) ? c0 : b1;
        c1 = (b1 < c0) ? b1 : c0;
        a2 = (a1 < b2) ? b2 : a1;
        b1 = (a1 < b2) ? a1 : b2;
        new_item.key   = {a2, b1, c1};
        new_item.start = in_start;
    end

    assign in_ready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // write slot: rd_ptr + fill, modulo two
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[rd_ptr_reg ^ fill_reg[0]] <= new_item;
        end
    end

endmodule

### sv/utsc_back.sv
// ----------------------------------------------------------------------------
// utsc_back
// Scans the key table for each queued key, updates counts, drives results.
// ----------------------------------------------------------------------------
module utsc_back
    import utsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  utsc_item_t       q_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_count,
    output logic             out_overflow
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_CMP
    } state_t;

    state_t            state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] used_reg, used_next;
    logic [FILL_W-1:0] singles_reg, singles_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_count_reg, out_count_next;
    logic              out_ovf_reg, out_ovf_next;

    logic [KEY_W-1:0]  key_mem [TABLE_ENTRIES];
    logic [1:0]        cnt_mem [TABLE_ENTRIES];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [1:0]        cnt_rd_reg;
    logic              rd_en, we;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [1:0]        wr_cnt;

    assign q_ready      = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid    = out_valid_reg;
    assign out_count    = out_count_reg;
    assign out_overflow = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        singles_next   = singles_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];
        we             = 1'b0;
        wr_addr        = idx_reg[ADDR_W-1:0];
        wr_cnt         = CNT_ONCE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    key_next   = q_item.key;
                    idx_next   = '0;
                    state_next = S_LOOK;
                    if (q_item.start)
                    begin
                        used_next    = '0;
                        singles_next = '0;
                    end
                end
            end
            S_LOOK:
            begin
                if (idx_reg < used_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    // key absent: append, or flag a full table
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (used_reg < FILL_W'(TABLE_ENTRIES))
                    begin
                        we           = 1'b1;
                        wr_addr      = used_reg[ADDR_W-1:0];
                        used_next    = used_reg + 1'b1;
                        singles_next = singles_reg + 1'b1;
                        out_ovf_next = 1'b0;
                    end
                    else
                    begin
                        out_ovf_next = 1'b1;
                    end
                    out_count_next = OUT_W'(singles_next);
                end
            end
            S_CMP:
            begin
                if (key_rd_reg == key_reg)
                begin
                    if (cnt_rd_reg == CNT_ONCE)
                    begin
                        we     = 1'b1;
                        wr_cnt = CNT_TWICE;
                        if (singles_reg != '0)
                        begin
                            singles_next = singles_reg - 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    out_ovf_next   = 1'b0;
                    out_count_next = OUT_W'(singles_next);
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOOK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            singles_reg   <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            key_reg       <= '0;
            out_count_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            singles_reg   <= singles_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            key_reg       <= key_next;
            out_count_reg <= out_count_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[wr_addr] <= key_reg;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            cnt_rd_reg <= cnt_mem[rd_addr];
        end
    end

endmodule

### sv/unique_triple_singleton_counter_unit.sv
// ----------------------------------------------------------------------------
// unique_triple_singleton_counter_unit
// Counts canonical triples seen exactly once in the current set.
// ----------------------------------------------------------------------------
// Each input beat carries three values and a start flag; the front sorts them
// into a key and queues it (two entries deep), so input is taken while the
// back is busy. The back scans the key table linearly through one read port,
// passing through S_LOOK and then S_CMP for each stored entry it examines
// (the match position, or all stored entries for a new key). One result beat
// follows every input beat; it is held in an output register until taken. No
// clearing pass is needed: the fill count bounds every lookup.
module unique_triple_singleton_counter_unit
    import utsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // value_a, value_b, value_c
    input  logic        s_axis_tuser,  // start_new_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // singleton_count, table_overflow, zero pad
);

    logic             q_valid, q_ready;
    utsc_item_t       q_item;
    logic [OUT_W-1:0] count;
    logic             overflow;

    utsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_a     (s_axis_tdata[15:0]),
        .in_b     (s_axis_tdata[31:16]),
        .in_c     (s_axis_tdata[47:32]),
        .in_start (s_axis_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    utsc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_count    (count),
        .out_overflow (overflow)
    );

    assign m_axis_tdata = {4'd0, overflow, count};

endmodule

### sv/utsc_checker.sv
// ----------------------------------------------------------------------------
// utsc_checker
// Port-level checks on the singleton counter, bound to the top level.
// ----------------------------------------------------------------------------
module utsc_checker
    import utsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic [2:0] pending_reg, pending_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // items taken in but whose result beat is not yet gone
    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result beat without a pending item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more items in flight than the design holds");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:0] <= OUT_W'(TABLE_ENTRIES)
                          && m_axis_tdata[15:12] == 4'd0)
        else $error("singleton count out of range");

endmodule

bind unique_triple_singleton_counter_unit utsc_checker u_utsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/tb_unique_triple_singleton_counter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_triple_singleton_counter_unit
// Self-checking bench for the canonical triple singleton counter.
// ----------------------------------------------------------------------------
// Triples stream in over the slave side in bursts with random gaps while the
// master side stalls on its own pattern. A scoreboard sorts each accepted
// triple, keeps its own key table with saturating counts and queues the
// expected singleton count and overflow flag, which every result beat is
// checked against. One pass grows the table to a couple of hundred entries
// for long scans; the rest uses small sets with frequent repeats.
// ----------------------------------------------------------------------------
module tb_unique_triple_singleton_counter_unit;
    import utsc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 6_000_000;
    localparam int          MAX_REPORTS = 10;
    localparam int          DEEP_KEYS   = 200;

    class singleton_scoreboard;
        logic [KEY_W-1:0] key_table [TABLE_ENTRIES];
        logic [1:0]       hit_count [TABLE_ENTRIES];
        int unsigned      used;
        int unsigned      singles;
        logic [OUT_W-1:0] count_q [$];
        logic             ovf_q [$];
        int               errors;

        function new();
            used    = 0;
            singles = 0;
            errors  = 0;
        endfunction

        function int pending();
            return count_q.size();
        endfunction

        // Predict the result of one accepted triple.
        function void note_triple(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                  logic start);
            logic [VALUE_BITS-1:0] t;
            logic [KEY_W-1:0]      key;
            int                    idx;
            logic                  ovf;
            idx = -1;
            ovf = 1'b0;
            if (a < b) begin t = a; a = b; b = t; end
            if (b < c) begin t = b; b = c; c = t; end
            if (a < b) begin t = a; a = b; b = t; end
            key = {a, b, c};
            if (start)
            begin
                used    = 0;
                singles = 0;
            end
            for (int i = 0; i < used; i++)
            begin
                if (key_table[i] == key)
                begin
                    idx = i;
                    break;
                end
            end
            if (idx >= 0)
            begin
                if (hit_count[idx] == CNT_ONCE)
                begin
                    hit_count[idx] = CNT_TWICE;
                    if (singles > 0)
                        singles--;
                end
            end
            else if (used < TABLE_ENTRIES)
            begin
                key_table[used] = key;
                hit_count[used] = CNT_ONCE;
                used++;
                singles++;
            end
            else
                ovf = 1'b1;
            count_q = {count_q, singles[OUT_W-1:0]};
            ovf_q   = {ovf_q, ovf};
        endfunction

        function void check_result(logic [15:0] data);
            logic [OUT_W-1:0] exp_count;
            logic             exp_ovf;
            if (count_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: count %0d overflow %0b",
                             data[10:0], data[11]);
                return;
            end
            exp_count = count_q.pop_front();
            exp_ovf   = ovf_q.pop_front();
            if (data[10:0] !== exp_count || data[11] !== exp_ovf)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                             exp_count, data[10:0], exp_ovf, data[11]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    singleton_scoreboard sb;
    int unsigned         cycles;
    int                  burst_left;
    int                  stall_mode;
    logic [15:0]         pool [8];

    unique_triple_singleton_counter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("unique_triple_singleton_counter_unit regression: fail");
            $finish;
        end
    end

    // Receiver: check each taken beat, stall on a pattern that shifts mode.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (cycles % 300 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Drive one beat and hold it until taken; may open a gap between bursts.
    task automatic send_triple(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                               logic start);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c, b, a};
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_triple(a, b, c, start);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return pool[$urandom_range(0, 7)];
        endcase
    endfunction

    initial
    begin
        logic [15:0] a, b, c;
        cycles        = 0;
        burst_left    = 0;
        stall_mode    = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every ordering of one triple, saturation, restart.
        send_triple(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_triple(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_triple(16'h0001, 16'h0002, 16'h0003, 1'b0);
        send_triple(16'h0001, 16'h0003, 16'h0002, 1'b0);
        send_triple(16'h0002, 16'h0001, 16'h0003, 1'b0);
        send_triple(16'h0002, 16'h0003, 16'h0001, 1'b0);
        send_triple(16'h0003, 16'h0001, 16'h0002, 1'b0);
        send_triple(16'h0003, 16'h0002, 16'h0001, 1'b0);
        send_triple(16'hFFFF, 16'h0000, 16'h5555, 1'b0);
        send_triple(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0);
        send_triple(16'h0000, 16'hFFFF, 16'hAAAA, 1'b0);
        send_triple(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        send_triple(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_triple(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_triple(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_triple(16'h1234, 16'h1234, 16'h1234, 1'b1);
        drain();

        // Grow the table deep, then hit it with new and known keys.
        for (int i = 0; i < DEEP_KEYS; i++)
        begin
            a = 16'(i + 2000);
            b = 16'(i);
            c = 16'($urandom_range(0, i));
            if ($urandom_range(0, 1))
                send_triple(c, a, b, i == 0);
            else
                send_triple(b, c, a, i == 0);
        end
        send_triple(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_triple(16'h0000, 16'h0005, 16'd2005, 1'b0);
        send_triple(16'hFFFE, 16'h0001, 16'h0000, 1'b0);
        send_triple(16'd2005, 16'h0005, 16'h0000, 1'b0);
        send_triple(16'd2001, 16'h0001, 16'h0000, 1'b0);
        drain();

        // Random: small sets drawn from a small value pool so repeats are common.
        for (int i = 0; i < 8; i++)
            pool[i] = 16'($urandom);
        for (int n = 0; n < 280; n++)
        begin
            if (n % 60 == 0)
                pool[$urandom_range(0, 7)] = 16'($urandom);
            a = pick_value();
            b = pick_value();
            c = pick_value();
            send_triple(a, b, c, $urandom_range(0, 11) == 0);
            if (n == 140)
                drain();
        end
        drain();
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("unique_triple_singleton_counter_unit regression: pass");
        else
            $display("unique_triple_singleton_counter_unit regression: fail");
        $finish;
    end

endmodule

### filelist.f
sv/utsc_pkg.sv
sv/utsc_front.sv
sv/utsc_back.sv
sv/unique_triple_singleton_counter_unit.sv
sv/utsc_checker.sv
verif/tb_unique_triple_singleton_counter_unit.sv
